// File: hw/rtl/fwq_pkg.sv
// shared widths, codes and defaults for the fifo wait queue
package fwq_pkg;

    localparam int DEF_MAX_THREADS = 16;

    localparam int CMD_W  = 2;
    localparam int TID_W  = 4;
    localparam int CODE_W = 16;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WAKE_ONE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WAKE_ALL = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY       = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_WAITING = 2'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY     = 2'd3;

    localparam int DEF_LINK_W = $clog2(DEF_MAX_THREADS);

endpackage

// File: hw/rtl/fwq_ram.sv
// generic single write port ram with registered read
module fwq_ram #(
    parameter int WIDTH = fwq_pkg::DEF_LINK_W,
    parameter int DEPTH = fwq_pkg::DEF_MAX_THREADS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fifo_wait_queue.sv
// fifo wait queue of thread ids kept as a circular doubly linked list in link rams
//
//   channel   valid        stall        payload
//   request   i_in_valid   o_in_stall   i_command, i_thread_id, i_return_code
//   result    o_out_valid  i_out_stall  o_thread_out, o_code_out, o_status,
//                                       o_last, o_more_waiters
//
// add, remove and wake-one read the link rams, then commit in the exec state; an add to a
// queue that already holds waiters finishes its own links in a second step; wake-all
// repeats the exec state for each waiter and emits one result per waiter.
// reset empties the queue at once, link rams need no clearing.
// a result waits in the output register; the next commit holds while it is stalled.
module fifo_wait_queue #(
    parameter int MAX_THREADS = fwq_pkg::DEF_MAX_THREADS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fwq_pkg::CMD_W-1:0]       i_command,
    input  logic [fwq_pkg::TID_W-1:0]       i_thread_id,
    input  logic signed [fwq_pkg::CODE_W-1:0] i_return_code,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fwq_pkg::TID_W-1:0]       o_thread_out,
    output logic signed [fwq_pkg::CODE_W-1:0] o_code_out,
    output logic [fwq_pkg::STAT_W-1:0]      o_status,
    output logic                            o_last,
    output logic                            o_more_waiters
);

    localparam int IW = $clog2(MAX_THREADS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ADD2 = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [fwq_pkg::CMD_W-1:0]         r_cmd;
    logic [fwq_pkg::TID_W-1:0]         r_tid;
    logic signed [fwq_pkg::CODE_W-1:0] r_code;
    logic [IW-1:0]                     r_head, n_head;
    logic                              r_nonempty, n_nonempty;
    logic [MAX_THREADS-1:0]            r_wait;
    logic [IW-1:0]                     r_tail, n_tail;

    logic          nx_we, nx_re, pv_we, pv_re;
    logic [IW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic [IW-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;
    logic          r_fwd_nx, r_fwd_pv;
    logic [IW-1:0] r_fwd_nx_data, r_fwd_pv_data;
    logic [IW-1:0] next_d, prev_d;

    logic          out_free;
    logic [IW-1:0] tid_idx, in_idx, ut;
    logic          tid_ok, is_waiting, unl_empty, do_unl;
    logic          wset, wclr;
    logic [IW-1:0] widx;

    logic                              emit, e_last;
    logic [fwq_pkg::TID_W-1:0]         e_thread;
    logic signed [fwq_pkg::CODE_W-1:0] e_code;
    logic [fwq_pkg::STAT_W-1:0]        e_status;

    logic                              r_out_valid;
    logic [fwq_pkg::TID_W-1:0]         r_out_thread;
    logic signed [fwq_pkg::CODE_W-1:0] r_out_code;
    logic [fwq_pkg::STAT_W-1:0]        r_out_status;
    logic                              r_out_last, r_out_more;

    fwq_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (nx_re),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    fwq_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (pv_re),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    assign next_d     = r_fwd_nx ? r_fwd_nx_data : nx_rdata;
    assign prev_d     = r_fwd_pv ? r_fwd_pv_data : pv_rdata;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign tid_idx    = IW'(r_tid);
    assign in_idx     = IW'(i_thread_id);
    assign tid_ok     = (32'(r_tid) < MAX_THREADS);
    assign is_waiting = tid_ok && r_wait[tid_idx];
    assign ut         = (r_cmd == fwq_pkg::CMD_REMOVE) ? tid_idx : r_head;
    assign unl_empty  = (next_d == ut);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_tail     = r_tail;
        nx_we      = 1'b0;
        nx_waddr   = tid_idx;
        nx_wdata   = r_head;
        nx_re      = 1'b0;
        nx_raddr   = r_head;
        pv_we      = 1'b0;
        pv_waddr   = tid_idx;
        pv_wdata   = r_head;
        pv_re      = 1'b0;
        pv_raddr   = r_head;
        wset       = 1'b0;
        wclr       = 1'b0;
        widx       = tid_idx;
        do_unl     = 1'b0;
        emit       = 1'b0;
        e_thread   = r_tid;
        e_code     = '0;
        e_status   = fwq_pkg::ST_OK;
        e_last     = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    nx_re = 1'b1;
                    pv_re = 1'b1;
                    if (i_command == fwq_pkg::CMD_REMOVE) begin
                        nx_raddr = in_idx;
                        pv_raddr = in_idx;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        fwq_pkg::CMD_ADD: begin
                            if (!tid_ok) begin
                                e_status = fwq_pkg::ST_NOT_WAITING;
                            end else if (r_wait[tid_idx]) begin
                                e_status = fwq_pkg::ST_ALREADY;
                            end else if (!r_nonempty) begin
                                nx_we      = 1'b1;
                                nx_wdata   = tid_idx;
                                pv_we      = 1'b1;
                                pv_wdata   = tid_idx;
                                n_head     = tid_idx;
                                n_nonempty = 1'b1;
                                wset       = 1'b1;
                            end else begin
                                // splice after the tail, finish own links next cycle
                                emit     = 1'b0;
                                n_tail   = prev_d;
                                nx_we    = 1'b1;
                                nx_waddr = prev_d;
                                nx_wdata = tid_idx;
                                pv_we    = 1'b1;
                                pv_waddr = r_head;
                                pv_wdata = tid_idx;
                                n_state  = S_ADD2;
                            end
                        end
                        fwq_pkg::CMD_REMOVE: begin
                            if (!r_nonempty) begin
                                e_status = fwq_pkg::ST_EMPTY;
                            end else if (!is_waiting) begin
                                e_status = fwq_pkg::ST_NOT_WAITING;
                            end else begin
                                do_unl = 1'b1;
                            end
                        end
                        default: begin
                            if (!r_nonempty) begin
                                e_thread = '0;
                                e_status = fwq_pkg::ST_EMPTY;
                            end else begin
                                do_unl   = 1'b1;
                                e_thread = fwq_pkg::TID_W'(r_head);
                                e_code   = r_code;
                                e_last   = (r_cmd == fwq_pkg::CMD_WAKE_ONE) || unl_empty;
                                if (r_cmd == fwq_pkg::CMD_WAKE_ALL && !unl_empty) begin
                                    // fetch links of the new head
                                    nx_re    = 1'b1;
                                    nx_raddr = next_d;
                                    pv_re    = 1'b1;
                                    pv_raddr = next_d;
                                    n_state  = S_EXEC;
                                end
                            end
                        end
                    endcase
                end
            end
            S_ADD2: begin
                if (out_free) begin
                    nx_we    = 1'b1;
                    nx_waddr = tid_idx;
                    nx_wdata = r_head;
                    pv_we    = 1'b1;
                    pv_waddr = tid_idx;
                    pv_wdata = r_tail;
                    wset     = 1'b1;
                    emit     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (do_unl) begin
            wclr = 1'b1;
            widx = ut;
            if (unl_empty) begin
                n_nonempty = 1'b0;
                n_head     = '0;
            end else begin
                if (ut == r_head) begin
                    n_head = next_d;
                end
                pv_we    = 1'b1;
                pv_waddr = next_d;
                pv_wdata = prev_d;
                nx_we    = 1'b1;
                nx_waddr = prev_d;
                nx_wdata = next_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            if (wset) begin
                r_wait[widx] <= 1'b1;
            end else if (wclr) begin
                r_wait[widx] <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_command;
            r_tid  <= i_thread_id;
            r_code <= i_return_code;
        end
        // bypass a write that lands on the entry being read
        if (nx_re) begin
            r_fwd_nx      <= nx_we && (nx_waddr == nx_raddr);
            r_fwd_nx_data <= nx_wdata;
        end
        if (pv_re) begin
            r_fwd_pv      <= pv_we && (pv_waddr == pv_raddr);
            r_fwd_pv_data <= pv_wdata;
        end
        if (emit) begin
            r_out_thread <= e_thread;
            r_out_code   <= e_code;
            r_out_status <= e_status;
            r_out_last   <= e_last;
            r_out_more   <= n_nonempty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_thread_out   = r_out_thread;
    assign o_code_out     = r_out_code;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;
    assign o_more_waiters = r_out_more;

endmodule
